>>> rtl/core/vii_pkg.sv
package vii_pkg;

  // Entry count, widths and list-register bit positions
  localparam int NumEntries  = 32;
  localparam int IdxW        = 5;
  localparam int GrpW        = 2;
  localparam int IdW         = 10;
  localparam int PrioW       = 8;
  localparam int CfgDataW    = 64;
  localparam int CfgIdxW     = 3;
  localparam int LrPrioShift = 23;
  localparam int LrPendBit   = 28;
  localparam int LrEoiBit    = 19;

  // Command codes
  localparam logic CMD_ASSERT    = 1'b0;
  localparam logic CMD_ENCOURAGE = 1'b1;

  // Status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_RANGE    = 2'd1;
  localparam logic [1:0] STATUS_DISABLED = 2'd2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_ENABLE    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_BASE      = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MASK      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_PRIO_LOW  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_PRIO_SEC  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_PRIO_THR  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_PRIO_HIGH = 3'd6;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic scan_step;
    logic load_result;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;
  } dp_sts_t;

endpackage

>>> rtl/core/vii_ctrl.sv
module vii_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             cmd,
  input  vii_pkg::dp_sts_t sts,
  output vii_pkg::dp_cmd_t ctl,
  output logic             busy,
  output logic             done
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_ASSERT = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;

  assign busy = (state != S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    ctl = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.capture = 1'b1;
          state_next = (cmd == vii_pkg::CMD_ENCOURAGE) ? S_SCAN : S_ASSERT;
        end
      end
      S_ASSERT: begin
        ctl.load_result = 1'b1;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (sts.scan_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        ctl.load_result = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ctl.load_result;
    end
  end

  a_done_after_load: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_ASSERT || state == S_FINISH))
    else $error("result beat without a load state");
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |-> !$past(done))
    else $error("result beats back to back");
  a_capture_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.capture |=> state == S_ASSERT || state == S_SCAN)
    else $error("capture did not leave idle");

endmodule

>>> rtl/core/vii_dp.sv
module vii_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  vii_pkg::dp_cmd_t                    ctl,
  output vii_pkg::dp_sts_t                    sts,
  input  logic                                cfg_we,
  input  logic [vii_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [vii_pkg::CfgDataW-1:0]        cfg_data,
  input  logic                                cmd,
  input  logic [vii_pkg::IdW-1:0]             irq_number,
  input  logic                                slot_busy,
  input  logic [2:0]                          current_cpu,
  input  logic [2:0]                          target_cpu,
  output logic [1:0]                          status,
  output logic                                injected,
  output logic [31:0]                         lr_word,
  output logic                                send_sgi,
  output logic [7:0]                          sgi_targets,
  output logic [vii_pkg::IdW-1:0]             injected_number,
  output logic [vii_pkg::NumEntries-1:0]      pending_bits
);

  // Configuration
  logic                                enable;
  logic [vii_pkg::IdW-1:0]             base_number;
  logic [vii_pkg::PrioW-1:0]           mask_level;
  logic [vii_pkg::CfgDataW-1:0]        prio_regs [4];
  logic [vii_pkg::NumEntries-1:0]      pending;

  // Captured beat
  logic                                cmd_r;
  logic [vii_pkg::IdW-1:0]             num_r;
  logic                                busy_r;
  logic [2:0]                          cur_r;
  logic [2:0]                          tgt_r;

  // Search state
  logic [vii_pkg::GrpW-1:0]            grp;
  logic [vii_pkg::PrioW-1:0]           best;
  logic                                found;
  logic [vii_pkg::IdxW-1:0]            pick;

  function automatic logic [vii_pkg::PrioW-1:0] prio_of(
    input logic [vii_pkg::CfgDataW-1:0] regs [4],
    input logic [vii_pkg::IdxW-1:0]     idx
  );
    logic [vii_pkg::CfgDataW-1:0] word;
    word = regs[idx[4:3]];
    return word[{idx[2:0], 3'b000} +: vii_pkg::PrioW];
  endfunction

  assign sts.scan_last = (grp == '0);

  // One group of eight per cycle, high index first, strict compare
  logic [vii_pkg::PrioW-1:0] s_best;
  logic                      s_found;
  logic [vii_pkg::IdxW-1:0]  s_pick;
  always_comb begin
    logic [vii_pkg::IdxW-1:0]  e;
    logic [vii_pkg::PrioW-1:0] p;
    s_best  = best;
    s_found = found;
    s_pick  = pick;
    for (int j = 7; j >= 0; j--) begin
      e = {grp, 3'(j)};
      p = prio_of(prio_regs, e);
      if (pending[e] && (p < s_best)) begin
        s_best  = p;
        s_found = 1'b1;
        s_pick  = e;
      end
    end
  end

  // Assert decode
  logic [vii_pkg::IdW:0]     base_end;
  logic                      in_range;
  logic [vii_pkg::IdW-1:0]   a_off;
  logic [vii_pkg::IdxW-1:0]  a_idx;
  assign base_end = {1'b0, base_number} + (vii_pkg::IdW+1)'(vii_pkg::NumEntries);
  assign in_range = (num_r >= base_number) && ({1'b0, num_r} < base_end);
  assign a_off    = num_r - base_number;
  assign a_idx    = a_off[vii_pkg::IdxW-1:0];

  // Result formation
  logic                                r_inject;
  logic [vii_pkg::IdxW-1:0]            r_idx;
  logic [1:0]                          r_status;
  logic [vii_pkg::NumEntries-1:0]      pend_next;
  logic [vii_pkg::PrioW-1:0]           r_prio;
  logic [vii_pkg::IdW-1:0]             r_id;
  logic [31:0]                         r_word;
  logic                                r_sgi;
  always_comb begin
    r_inject  = 1'b0;
    r_idx     = a_idx;
    r_status  = vii_pkg::STATUS_OK;
    pend_next = pending;
    if (cmd_r == vii_pkg::CMD_ASSERT) begin
      if (!enable) begin
        r_status = vii_pkg::STATUS_DISABLED;
      end else if (!in_range) begin
        r_status = vii_pkg::STATUS_RANGE;
      end else if ((prio_of(prio_regs, a_idx) != mask_level) && !busy_r) begin
        r_inject = 1'b1;
      end else begin
        pend_next[a_idx] = 1'b1;
      end
    end else begin
      r_idx = pick;
      if (found && !busy_r) begin
        r_inject = 1'b1;
        pend_next[pick] = 1'b0;
      end
    end
    r_prio = prio_of(prio_regs, r_idx);
    r_id   = base_number + vii_pkg::IdW'(r_idx);
    r_word = (32'(r_prio) << vii_pkg::LrPrioShift) | (32'd1 << vii_pkg::LrPendBit)
           | (32'd1 << vii_pkg::LrEoiBit) | 32'(r_id);
    r_sgi  = r_inject && (cur_r != tgt_r);
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= 1'b0;
      base_number   <= vii_pkg::IdW'(32);
      mask_level    <= '1;
      for (int i = 0; i < 4; i++) prio_regs[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        vii_pkg::REG_ENABLE:    enable        <= cfg_data[0];
        vii_pkg::REG_BASE:      base_number   <= cfg_data[vii_pkg::IdW-1:0];
        vii_pkg::REG_MASK:      mask_level    <= cfg_data[vii_pkg::PrioW-1:0];
        vii_pkg::REG_PRIO_LOW:  prio_regs[0]  <= cfg_data;
        vii_pkg::REG_PRIO_SEC:  prio_regs[1]  <= cfg_data;
        vii_pkg::REG_PRIO_THR:  prio_regs[2]  <= cfg_data;
        vii_pkg::REG_PRIO_HIGH: prio_regs[3]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Beat capture and search registers
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r  <= cmd;
      num_r  <= irq_number;
      busy_r <= slot_busy;
      cur_r  <= current_cpu;
      tgt_r  <= target_cpu;
      grp    <= '1;
      best   <= mask_level;
      found  <= 1'b0;
      pick   <= '0;
    end else if (ctl.scan_step) begin
      grp   <= grp - 1'b1;
      best  <= s_best;
      found <= s_found;
      pick  <= s_pick;
    end
  end

  // Pending map and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pending         <= '0;
      status          <= vii_pkg::STATUS_OK;
      injected        <= 1'b0;
      lr_word         <= '0;
      send_sgi        <= 1'b0;
      sgi_targets     <= '0;
      injected_number <= '0;
      pending_bits    <= '0;
    end else if (ctl.load_result) begin
      pending         <= pend_next;
      status          <= r_status;
      injected        <= r_inject;
      lr_word         <= r_inject ? r_word : '0;
      send_sgi        <= r_sgi;
      sgi_targets     <= r_sgi ? (8'd1 << tgt_r) : '0;
      injected_number <= r_inject ? r_id : '0;
      pending_bits    <= pend_next;
    end
  end

  a_lr_form: assert property (@(posedge clk) disable iff (rst)
    injected |-> lr_word[vii_pkg::LrPendBit] && lr_word[vii_pkg::LrEoiBit]
                 && (lr_word[vii_pkg::IdW-1:0] == injected_number))
    else $error("list-register word malformed");
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    !injected |-> (lr_word == '0) && (injected_number == '0) && !send_sgi)
    else $error("injection fields set without injection");
  a_sgi_mask: assert property (@(posedge clk) disable iff (rst)
    send_sgi ? ($onehot(sgi_targets) && injected) : (sgi_targets == '0))
    else $error("sgi target mask inconsistent");

endmodule

>>> rtl/core/virtual_interrupt_injector.sv
// Channel   Handshake        Ports
// -------   ---------        -----
// command   start / busy     cmd irq_number slot_busy current_cpu target_cpu
// result    done strobe      status injected lr_word send_sgi sgi_targets
//                            injected_number pending_bits
// config    cfg_we           cfg_index cfg_data
//
// An assert beat loads its result in S_ASSERT, the state after accept.
// An encourage beat first runs the minimum-priority search, which walks the 32
// entries as four groups of eight, one group per cycle, then loads.
// busy stays high until the done cycle; a new beat may be taken then.
// rst (synchronous) resets all but the captured beat and search registers.
// Results cannot be stalled: each stays on the ports until the next load.
module virtual_interrupt_injector (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            cmd,
  input  logic [vii_pkg::IdW-1:0]         irq_number,
  input  logic                            slot_busy,
  input  logic [2:0]                      current_cpu,
  input  logic [2:0]                      target_cpu,
  input  logic                            cfg_we,
  input  logic [vii_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [vii_pkg::CfgDataW-1:0]    cfg_data,
  output logic                            done,
  output logic [1:0]                      status,
  output logic                            injected,
  output logic [31:0]                     lr_word,
  output logic                            send_sgi,
  output logic [7:0]                      sgi_targets,
  output logic [vii_pkg::IdW-1:0]         injected_number,
  output logic [vii_pkg::NumEntries-1:0]  pending_bits
);

  vii_pkg::dp_cmd_t ctl;
  vii_pkg::dp_sts_t sts;

  vii_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  vii_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .irq_number      (irq_number),
    .slot_busy       (slot_busy),
    .current_cpu     (current_cpu),
    .target_cpu      (target_cpu),
    .status          (status),
    .injected        (injected),
    .lr_word         (lr_word),
    .send_sgi        (send_sgi),
    .sgi_targets     (sgi_targets),
    .injected_number (injected_number),
    .pending_bits    (pending_bits)
  );

endmodule

>>> bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Index outside the register map; writes to it must change nothing
  localparam logic [vii_pkg::CfgIdxW-1:0] RegUnused = 3'd7;

  typedef struct packed {
    logic                      cmd;
    logic [vii_pkg::IdW-1:0]   irq;
    logic                      slot;
    logic [2:0]                cur;
    logic [2:0]                tgt;
  } inj_cmd_t;

  typedef struct packed {
    logic [1:0]                     status;
    logic                           injected;
    logic [31:0]                    lr_word;
    logic                           send_sgi;
    logic [7:0]                     sgi_targets;
    logic [vii_pkg::IdW-1:0]        number;
    logic [vii_pkg::NumEntries-1:0] pending;
  } inj_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                             start = 1'b0;
  logic                             busy;
  logic                             cmd = vii_pkg::CMD_ASSERT;
  logic [vii_pkg::IdW-1:0]          irq_number = '0;
  logic                             slot_busy = 1'b0;
  logic [2:0]                       current_cpu = '0;
  logic [2:0]                       target_cpu = '0;
  logic                             cfg_we = 1'b0;
  logic [vii_pkg::CfgIdxW-1:0]      cfg_index = '0;
  logic [vii_pkg::CfgDataW-1:0]     cfg_data = '0;
  logic                             done;
  logic [1:0]                       status;
  logic                             injected;
  logic [31:0]                      lr_word;
  logic                             send_sgi;
  logic [7:0]                       sgi_targets;
  logic [vii_pkg::IdW-1:0]          injected_number;
  logic [vii_pkg::NumEntries-1:0]   pending_bits;

  virtual_interrupt_injector u_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .cmd             (cmd),
    .irq_number      (irq_number),
    .slot_busy       (slot_busy),
    .current_cpu     (current_cpu),
    .target_cpu      (target_cpu),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .done            (done),
    .status          (status),
    .injected        (injected),
    .lr_word         (lr_word),
    .send_sgi        (send_sgi),
    .sgi_targets     (sgi_targets),
    .injected_number (injected_number),
    .pending_bits    (pending_bits)
  );

  always #5 clk = ~clk;

  // Shadow copy of the injector's registers and pending map
  logic                           shadow_enable = 1'b0;
  logic [vii_pkg::IdW-1:0]        shadow_base = 10'd32;
  logic [vii_pkg::PrioW-1:0]      shadow_mask = 8'hFF;
  logic [vii_pkg::PrioW-1:0]      shadow_prio [vii_pkg::NumEntries] = '{default: '0};
  logic [vii_pkg::NumEntries-1:0] shadow_pending = '0;

  logic [vii_pkg::CfgIdxW-1:0] prio_reg_idx [4] = '{vii_pkg::REG_PRIO_LOW,
                                                    vii_pkg::REG_PRIO_SEC,
                                                    vii_pkg::REG_PRIO_THR,
                                                    vii_pkg::REG_PRIO_HIGH};

  inj_cmd_t    command_queue [$];
  inj_result_t injection_reports [$];
  inj_cmd_t    on_port;
  int          sender_idle_pct = 0;
  int          err_count = 0;

  // Fill in the list-register word and SGI request for entry idx
  function automatic void load_injection(inout inj_result_t r, input int unsigned idx,
                                         input inj_cmd_t c);
    logic [vii_pkg::IdW-1:0] id;
    id = vii_pkg::IdW'(shadow_base + idx);
    r.injected = 1'b1;
    r.lr_word  = (32'(shadow_prio[idx]) << vii_pkg::LrPrioShift) |
                 (32'd1 << vii_pkg::LrPendBit) | (32'd1 << vii_pkg::LrEoiBit) | 32'(id);
    if (c.cur != c.tgt) begin
      r.send_sgi    = 1'b1;
      r.sgi_targets = 8'd1 << c.tgt;
    end
    r.number = id;
  endfunction

  // Expected result of one command beat; updates the shadow pending map
  function automatic inj_result_t predict_injection(input inj_cmd_t c);
    inj_result_t r;
    int unsigned num;
    int unsigned base;
    int unsigned idx;
    int unsigned best;
    int unsigned pick;
    bit          found;
    r = '0;
    r.status = vii_pkg::STATUS_OK;
    num  = c.irq;
    base = shadow_base;
    if (c.cmd == vii_pkg::CMD_ASSERT) begin
      if (!shadow_enable) begin
        r.status = vii_pkg::STATUS_DISABLED;
      end else if (num < base || num >= base + vii_pkg::NumEntries) begin
        r.status = vii_pkg::STATUS_RANGE;
      end else begin
        idx = num - base;
        if (shadow_prio[idx] != shadow_mask && !c.slot) begin
          load_injection(r, idx, c);
        end else begin
          shadow_pending[idx] = 1'b1;
        end
      end
    end else if (shadow_pending != '0 && !c.slot) begin
      // strict compare while walking down: highest index wins ties
      best  = shadow_mask;
      pick  = 0;
      found = 1'b0;
      for (int i = vii_pkg::NumEntries - 1; i >= 0; i--) begin
        if (shadow_pending[i] && shadow_prio[i] < best) begin
          best  = shadow_prio[i];
          pick  = i;
          found = 1'b1;
        end
      end
      if (found) begin
        load_injection(r, pick, c);
        shadow_pending[pick] = 1'b0;
      end
    end
    r.pending = shadow_pending;
    return r;
  endfunction

  // Command driver: holds a beat while busy, random gaps when free
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        injection_reports.push_back(predict_injection(on_port));
      end
      if (!(start && busy)) begin
        if (command_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          on_port = command_queue.pop_front();
          start       <= 1'b1;
          cmd         <= on_port.cmd;
          irq_number  <= on_port.irq;
          slot_busy   <= on_port.slot;
          current_cpu <= on_port.cur;
          target_cpu  <= on_port.tgt;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string field, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      err_count++;
      if (err_count <= 10) begin
        $display("[%0t] %s mismatch: expected 0x%0h, got 0x%0h", $time, field, want, got);
      end
    end
  endtask

  // Result monitor: every done strobe is one beat, checked in order
  inj_result_t want;
  always @(posedge clk) begin
    if (!rst && done) begin
      if (injection_reports.size() == 0) begin
        err_count++;
        if (err_count <= 10) begin
          $display("[%0t] result with no command outstanding: status %0d lr_word 0x%0h",
                   $time, status, lr_word);
        end
      end else begin
        want = injection_reports.pop_front();
        check_field("status", status, want.status);
        check_field("injected", injected, want.injected);
        check_field("lr_word", lr_word, want.lr_word);
        check_field("send_sgi", send_sgi, want.send_sgi);
        check_field("sgi_targets", sgi_targets, want.sgi_targets);
        check_field("injected_number", injected_number, want.number);
        check_field("pending_bits", pending_bits, want.pending);
      end
    end
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // One register write, then release the enable
  task automatic write_reg(input logic [vii_pkg::CfgIdxW-1:0] idx,
                           input logic [vii_pkg::CfgDataW-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      vii_pkg::REG_ENABLE: shadow_enable = data[0];
      vii_pkg::REG_BASE:   shadow_base = data[vii_pkg::IdW-1:0];
      vii_pkg::REG_MASK:   shadow_mask = data[vii_pkg::PrioW-1:0];
      default: begin
        for (int g = 0; g < 4; g++) begin
          if (idx == prio_reg_idx[g]) begin
            for (int b = 0; b < 8; b++) shadow_prio[g * 8 + b] = data[b * 8 +: 8];
          end
        end
      end
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Narrow register with junk in the unused upper bits
  task automatic write_field(input logic [vii_pkg::CfgIdxW-1:0] idx, input int width,
                             input logic [vii_pkg::CfgDataW-1:0] value);
    logic [63:0] keep;
    keep = (64'd1 << width) - 64'd1;
    write_reg(idx, (rand_word() & ~keep) | (value & keep));
  endtask

  function automatic void push_cmd(input logic c, input logic [vii_pkg::IdW-1:0] n,
                                   input logic s, input logic [2:0] cu,
                                   input logic [2:0] tg);
    inj_cmd_t it;
    it.cmd  = c;
    it.irq  = n;
    it.slot = s;
    it.cur  = cu;
    it.tgt  = tg;
    command_queue.push_back(it);
  endfunction

  function automatic logic [7:0] pick_prio(input logic [7:0] mask);
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return mask;
      3:       return 8'($urandom_range(0, 3));
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly in-window asserts and encourages, some stray numbers
  function automatic void push_random_cmd();
    int unsigned             span;
    logic [vii_pkg::IdW-1:0] n;
    logic [2:0]              cu;
    logic [2:0]              tg;
    span = (shadow_base > 992) ? 1023 - shadow_base : 31;
    if ($urandom_range(0, 4) == 0) n = vii_pkg::IdW'($urandom_range(0, 1023));
    else n = vii_pkg::IdW'(shadow_base + $urandom_range(0, span));
    cu = 3'($urandom);
    tg = ($urandom_range(0, 9) < 3) ? cu : 3'($urandom);
    push_cmd(($urandom_range(0, 99) < 45) ? vii_pkg::CMD_ENCOURAGE : vii_pkg::CMD_ASSERT, n,
             $urandom_range(0, 99) < 35, cu, tg);
  endfunction

  // Idle once every beat has been sent and answered
  task automatic wait_quiet();
    do @(negedge clk);
    while (command_queue.size() != 0 || start || busy || injection_reports.size() != 0);
  endtask

  initial begin
    logic [63:0] prio_word;
    int unsigned base_val;
    logic [7:0]  mask_val;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Disabled after reset: assert refused, encourage has nothing to do
    push_cmd(vii_pkg::CMD_ASSERT, 10'd40, 1'b0, 3'd0, 3'd0);
    push_cmd(vii_pkg::CMD_ENCOURAGE, 10'h3FF, 1'b0, 3'd7, 3'd7);
    wait_quiet();

    write_field(vii_pkg::REG_ENABLE, 1, 1);
    write_field(vii_pkg::REG_BASE, vii_pkg::IdW, 32);
    write_field(vii_pkg::REG_MASK, vii_pkg::PrioW, 8'h80);
    write_reg(vii_pkg::REG_PRIO_LOW, 64'h00FF_8010_1005_8000);
    write_reg(vii_pkg::REG_PRIO_SEC, 64'h8080_0000_FFFF_1010);
    write_reg(vii_pkg::REG_PRIO_THR, 64'h7F81_0102_0304_0506);
    write_reg(vii_pkg::REG_PRIO_HIGH, 64'h0123_4567_89AB_CDEF);

    // Range edges, direct injection with and without SGI, pending cases
    push_cmd(vii_pkg::CMD_ASSERT, 10'd31, 1'b0, 3'd0, 3'd0);
    push_cmd(vii_pkg::CMD_ASSERT, 10'd64, 1'b0, 3'd0, 3'd0);
    push_cmd(vii_pkg::CMD_ASSERT, 10'd1023, 1'b0, 3'd0, 3'd0);
    push_cmd(vii_pkg::CMD_ASSERT, 10'd0, 1'b0, 3'd0, 3'd0);
    push_cmd(vii_pkg::CMD_ASSERT, 10'd32, 1'b0, 3'd3, 3'd3);
    push_cmd(vii_pkg::CMD_ASSERT, 10'd32, 1'b0, 3'd0, 3'd7);
    push_cmd(vii_pkg::CMD_ASSERT, 10'd33, 1'b0, 3'd1, 3'd2);
    push_cmd(vii_pkg::CMD_ASSERT, 10'd38, 1'b0, 3'd7, 3'd0);
    push_cmd(vii_pkg::CMD_ASSERT, 10'd35, 1'b1, 3'd0, 3'd0);
    push_cmd(vii_pkg::CMD_ASSERT, 10'd36, 1'b1, 3'd0, 3'd0);
    push_cmd(vii_pkg::CMD_ASSERT, 10'd63, 1'b1, 3'd0, 3'd0);
    push_cmd(vii_pkg::CMD_ASSERT, 10'd38, 1'b1, 3'd0, 3'd0);
    // Encourage: slot busy, lowest priority, tie on equal priority, nothing eligible
    push_cmd(vii_pkg::CMD_ENCOURAGE, 10'd0, 1'b1, 3'd0, 3'd1);
    push_cmd(vii_pkg::CMD_ENCOURAGE, 10'h2AA, 1'b0, 3'd1, 3'd1);
    push_cmd(vii_pkg::CMD_ENCOURAGE, 10'h155, 1'b0, 3'd2, 3'd5);
    push_cmd(vii_pkg::CMD_ENCOURAGE, 10'd0, 1'b0, 3'd4, 3'd6);
    push_cmd(vii_pkg::CMD_ENCOURAGE, 10'd0, 1'b0, 3'd0, 3'd0);
    push_cmd(vii_pkg::CMD_ASSERT, 10'd63, 1'b1, 3'd0, 3'd0);
    push_cmd(vii_pkg::CMD_ASSERT, 10'd62, 1'b1, 3'd0, 3'd0);
    wait_quiet();

    // High base: pending high entries wrap past ten bits on injection
    write_field(vii_pkg::REG_BASE, vii_pkg::IdW, 1010);
    write_field(vii_pkg::REG_MASK, vii_pkg::PrioW, 8'hFF);
    push_cmd(vii_pkg::CMD_ENCOURAGE, 10'd0, 1'b0, 3'd5, 3'd2);
    push_cmd(vii_pkg::CMD_ENCOURAGE, 10'd0, 1'b0, 3'd2, 3'd2);
    push_cmd(vii_pkg::CMD_ASSERT, 10'd1009, 1'b0, 3'd0, 3'd0);
    push_cmd(vii_pkg::CMD_ASSERT, 10'd1023, 1'b0, 3'd6, 3'd1);
    wait_quiet();

    // Zero mask blocks every encourage; then encourage while disabled
    write_field(vii_pkg::REG_MASK, vii_pkg::PrioW, 8'h00);
    push_cmd(vii_pkg::CMD_ENCOURAGE, 10'd0, 1'b0, 3'd0, 3'd0);
    wait_quiet();
    write_field(vii_pkg::REG_ENABLE, 1, 0);
    write_field(vii_pkg::REG_MASK, vii_pkg::PrioW, 8'hFF);
    push_cmd(vii_pkg::CMD_ENCOURAGE, 10'd0, 1'b0, 3'd3, 3'd4);

    // Random phases over a spread of settings and sender gaps
    for (int p = 0; p < 8; p++) begin
      wait_quiet();
      case (p)
        0:       base_val = 0;
        1:       base_val = 992;
        3:       base_val = 1010;
        5:       base_val = 32;
        default: base_val = $urandom_range(1, 991);
      endcase
      case (p)
        0, 4:    mask_val = 8'hFF;
        1:       mask_val = 8'h80;
        3:       mask_val = 8'h00;
        6:       mask_val = 8'h01;
        default: mask_val = 8'($urandom);
      endcase
      write_field(vii_pkg::REG_ENABLE, 1, (p == 5) ? 0 : 1);
      write_field(vii_pkg::REG_BASE, vii_pkg::IdW, base_val);
      write_field(vii_pkg::REG_MASK, vii_pkg::PrioW, mask_val);
      for (int g = 0; g < 4; g++) begin
        for (int b = 0; b < 8; b++) prio_word[b * 8 +: 8] = pick_prio(mask_val);
        write_reg(prio_reg_idx[g], prio_word);
      end
      write_reg(RegUnused, rand_word());
      case (p % 4)
        1:       sender_idle_pct = 50;
        3:       sender_idle_pct = 7;
        default: sender_idle_pct = 0;
      endcase
      repeat (140) push_random_cmd();
    end

    wait_quiet();
    repeat (10) @(posedge clk);
    if (err_count == 0 && injection_reports.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
